// File: rtl/pow_difficulty_retarget_defines.svh
// ---------------------------------------------------------------------------
// pow_difficulty_retarget_defines
// Assertion macros shared by the retarget block.
// ---------------------------------------------------------------------------
`ifndef POW_DIFFICULTY_RETARGET_DEFINES_SVH
`define POW_DIFFICULTY_RETARGET_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PDR_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("pdr assertion failed");

// Next-cycle implication, checked out of reset
`define PDR_ASSERT_NXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("pdr assertion failed");

`endif

// File: rtl/pdr_pkg.sv
// ---------------------------------------------------------------------------
// pdr_pkg
// Types and constants of the difficulty retarget pipeline.
// ---------------------------------------------------------------------------
package pdr_pkg;

    localparam int VALUE_W       = 256;
    localparam int HALVE_ABOVE   = 235;
    localparam int SPAN_SHIFT    = 2;     // clamp window is T/4 .. 4T
    localparam int LIMB_W        = 32;
    localparam int LIMBS         = VALUE_W / LIMB_W;
    localparam int DIV_STEPS     = 4;     // quotient bits per divider stage
    localparam int DIV_STAGES    = VALUE_W / DIV_STEPS;
    localparam int TS_W          = 30;
    localparam int LIM_W         = 9;

    // Register indexes
    localparam logic [1:0] REG_TIMESPAN   = 2'd0;
    localparam logic [1:0] REG_LIMIT_BITS = 2'd1;
    localparam logic [1:0] REG_NO_RETGT   = 2'd2;

    localparam logic [TS_W-1:0]  TIMESPAN_RST   = 30'd302400;
    localparam logic [LIM_W-1:0] LIMIT_BITS_RST = 9'd236;

    typedef struct packed {
        logic [TS_W-1:0]  timespan;
        logic [LIM_W-1:0] limit_bits;
        logic             no_retarget;
    } pdr_cfg_t;

    // Divider payload: dividend shifts out at the top, quotient in at the bottom
    typedef struct packed {
        logic [VALUE_W-1:0] word;
        logic [TS_W-1:0]    rem;
        logic               halved;
        logic [31:0]        last_bits;
    } pdr_div_t;

endpackage

// File: rtl/pow_difficulty_retarget.sv
// ---------------------------------------------------------------------------
// pow_difficulty_retarget
// Compact-target difficulty retarget, fully pipelined.
// ---------------------------------------------------------------------------
//  channel  | ports                               | direction
//  ---------+-------------------------------------+----------
//  input    | s_valid s_ready s_last_bits ...     | in
//  result   | m_valid m_ready m_next_bits         | out
//  config   | cfg_valid cfg_ready cfg_index/data  | in
//
// One beat per cycle in, one per cycle out while no result is held. Stages:
// 3 front stages, 64 divider stages of 4 quotient bits, 3 encode stages.
// The divider stage chain is the longest part of the pipeline.
// Reset clears valid bits and restores register defaults; no clearing pass.
// A held result stalls every stage together; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "pow_difficulty_retarget_defines.svh"

module pow_difficulty_retarget import pdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_last_bits,
    input  logic [31:0] s_last_time,
    input  logic [31:0] s_first_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    pdr_cfg_t cfg_reg;
    logic     en;
    logic     div_valid [DIV_STAGES+1];
    pdr_div_t div_data  [DIV_STAGES+1];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timespan    <= TIMESPAN_RST;
            cfg_reg.limit_bits  <= LIMIT_BITS_RST;
            cfg_reg.no_retarget <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TIMESPAN:   cfg_reg.timespan    <= cfg_data[TS_W-1:0];
                REG_LIMIT_BITS: cfg_reg.limit_bits  <= cfg_data[LIM_W-1:0];
                REG_NO_RETGT:   cfg_reg.no_retarget <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Whole pipeline moves unless the result beat is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    pdr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .cfg        (cfg_reg),
        .in_valid   (s_valid),
        .last_bits  (s_last_bits),
        .last_time  (s_last_time),
        .first_time (s_first_time),
        .out_valid  (div_valid[0]),
        .out_data   (div_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        pdr_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .divisor   (cfg_reg.timespan),
            .in_valid  (div_valid[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    pdr_encode u_encode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_data   (div_data[DIV_STAGES]),
        .out_valid (m_valid),
        .next_bits (m_next_bits)
    );

    // Checks
    `PDR_ASSERT_IMP(a_sign_clear, aclk, aresetn, m_valid && !cfg_reg.no_retarget, !m_next_bits[23])
    `PDR_ASSERT_IMP(a_exp_range, aclk, aresetn, m_valid && !cfg_reg.no_retarget, m_next_bits[31:24] <= 8'd33)
    `PDR_ASSERT_NXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && !$past(s_ready))

endmodule

// File: rtl/pdr_front.sv
// ---------------------------------------------------------------------------
// pdr_front
// Span clamp, compact decode, halving and 256x32 multiply (three stages).
// ---------------------------------------------------------------------------
module pdr_front import pdr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  pdr_cfg_t         cfg,
    input  logic             in_valid,
    input  logic [31:0]      last_bits,
    input  logic [31:0]      last_time,
    input  logic [31:0]      first_time,
    output logic             out_valid,
    output pdr_div_t         out_data
);

    logic [2:0]          valid_reg;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [31:0]         span_reg, span_next;
    logic [31:0]         bits1_reg, bits2_reg;
    logic [63:0]         pp_reg [LIMBS];
    logic [63:0]         pp_next [LIMBS];
    logic                halved_reg, halved_next;
    pdr_div_t            data_reg, data_next;

    // Stage 1: clamp the time difference, expand the compact target
    always_comb begin
        logic signed [32:0] diff;
        logic [27:0]        lo;
        logic [31:0]        hi;
        logic [7:0]         size;
        logic [VALUE_W-1:0] ext;
        logic [4:0]         amt;
        diff = $signed({1'b0, last_time}) - $signed({1'b0, first_time});
        lo   = cfg.timespan[TS_W-1:SPAN_SHIFT];
        hi   = {cfg.timespan, 2'b00};
        if (diff < $signed({5'd0, lo})) begin
            span_next = {4'd0, lo};
        end else if (diff > $signed({1'b0, hi})) begin
            span_next = hi;
        end else begin
            span_next = diff[31:0];
        end
        size = last_bits[31:24];
        ext  = {{(VALUE_W-23){1'b0}}, last_bits[22:0]};
        amt  = 5'(size - 8'd3);
        if (size <= 8'd3) begin
            val_next = ext >> {5'(8'd3 - size), 3'b000};
        end else if (size >= 8'd35) begin
            val_next = '0;
        end else begin
            val_next = ext << {amt, 3'b000};
        end
    end

    // Stage 2: halve wide values, one 32x32 product per limb
    always_comb begin
        logic [VALUE_W-1:0] v;
        halved_next = |val_reg[VALUE_W-1:HALVE_ABOVE];
        v = halved_next ? (val_reg >> 1) : val_reg;
        for (int i = 0; i < LIMBS; i++) begin
            pp_next[i] = v[LIMB_W*i +: LIMB_W] * span_reg;
        end
    end

    // Stage 3: add low and high halves of the partial products
    always_comb begin
        logic [VALUE_W-1:0] lo_sum, hi_sum;
        lo_sum = '0;
        hi_sum = '0;
        for (int i = 0; i < LIMBS; i++) begin
            lo_sum[LIMB_W*i +: LIMB_W] = pp_reg[i][31:0];
        end
        for (int i = 0; i < LIMBS-1; i++) begin
            hi_sum[LIMB_W*(i+1) +: LIMB_W] = pp_reg[i][63:32];
        end
        data_next.word      = lo_sum + hi_sum;
        data_next.rem       = '0;
        data_next.halved    = halved_reg;
        data_next.last_bits = bits2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg    <= val_next;
            span_reg   <= span_next;
            bits1_reg  <= last_bits;
            pp_reg     <= pp_next;
            halved_reg <= halved_next;
            bits2_reg  <= bits1_reg;
            data_reg   <= data_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = data_reg;

endmodule

// File: rtl/pdr_div_stage.sv
// ---------------------------------------------------------------------------
// pdr_div_stage
// One stage of the restoring divider: DIV_STEPS quotient bits per stage.
// ---------------------------------------------------------------------------
module pdr_div_stage import pdr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [TS_W-1:0]  divisor,
    input  logic             in_valid,
    input  pdr_div_t         in_data,
    output logic             out_valid,
    output pdr_div_t         out_data
);

    logic     valid_reg;
    pdr_div_t data_reg, data_next;

    // Shift-subtract steps
    always_comb begin
        logic [TS_W:0] r;
        logic          q;
        data_next = in_data;
        for (int s = 0; s < DIV_STEPS; s++) begin
            r = {data_next.rem, data_next.word[VALUE_W-1]};
            q = (r >= {1'b0, divisor});
            if (q) begin
                r = r - {1'b0, divisor};
            end
            data_next.rem  = r[TS_W-1:0];
            data_next.word = {data_next.word[VALUE_W-2:0], q};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/pdr_encode.sv
// ---------------------------------------------------------------------------
// pdr_encode
// Undo halving, clamp to the limit and pack into compact form (three stages).
// ---------------------------------------------------------------------------
module pdr_encode import pdr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  pdr_cfg_t         cfg,
    input  logic             in_valid,
    input  pdr_div_t         in_data,
    output logic             out_valid,
    output logic [31:0]      next_bits
);

    logic [2:0]          valid_reg;
    logic [VALUE_W-1:0]  val1_reg, val1_next, val2_reg;
    logic [31:0]         bits1_reg, bits2_reg;
    logic [5:0]          size_reg, size_next;
    logic [31:0]         out_reg, out_next;

    // Stage 1: double back, limit select and clamp; zero timespan gives limit
    always_comb begin
        logic [VALUE_W-1:0] lim, d;
        logic [LIM_W-1:0]   n;
        n = (cfg.limit_bits > LIM_W'(VALUE_W)) ? LIM_W'(VALUE_W) : cfg.limit_bits;
        for (int i = 0; i < VALUE_W; i++) begin
            lim[i] = (LIM_W'(i) < n);
        end
        d = in_data.halved ? {in_data.word[VALUE_W-2:0], 1'b0} : in_data.word;
        if (cfg.timespan == '0) begin
            d = lim;
        end
        val1_next = (|(d & ~lim)) ? lim : d;
    end

    // Stage 2: byte length of the value
    always_comb begin
        size_next = '0;
        for (int i = 0; i < VALUE_W/8; i++) begin
            if (|val1_reg[8*i +: 8]) begin
                size_next = 6'(i + 1);
            end
        end
    end

    // Stage 3: top three bytes, sign bit clear; or last_bits if no_retarget
    always_comb begin
        logic [VALUE_W+23:0] ext;
        logic [23:0]         mant;
        logic [7:0]          size;
        ext  = {val2_reg, 24'd0};
        mant = ext[{size_reg, 3'b000} +: 24];
        size = {2'b00, size_reg};
        if (mant[23]) begin
            mant = {8'd0, mant[23:8]};
            size = size + 8'd1;
        end
        out_next = cfg.no_retarget ? bits2_reg : {size, mant};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val1_reg  <= val1_next;
            bits1_reg <= in_data.last_bits;
            val2_reg  <= val1_reg;
            bits2_reg <= bits1_reg;
            size_reg  <= size_next;
            out_reg   <= out_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign next_bits = out_reg;

endmodule

// File: dv/tb_pow_difficulty_retarget.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pow_difficulty_retarget
// Self-checking bench for the compact-target retarget pipeline. Directed
// corner beats, then random beats under several register settings and three
// back-pressure profiles. Results are predicted at input acceptance and
// checked in order at the output.
// ---------------------------------------------------------------------------
module tb_pow_difficulty_retarget;
    import pdr_pkg::*;

    typedef struct {
        logic [31:0] last_bits;
        logic [31:0] last_time;
        logic [31:0] first_time;
    } retarget_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_last_bits = '0;
    logic [31:0] s_last_time = '0;
    logic [31:0] s_first_time = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_next_bits;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Shadow copy of the block's registers
    logic [29:0] span_target = 30'd302400;
    logic [8:0]  limit_bits  = 9'd236;
    logic        pass_through = 1'b0;

    retarget_req_t   pending_reqs[$];
    logic [31:0]     expected_bits[$];
    int unsigned     send_idle_pct  = 10;
    int unsigned     recv_stall_pct = 80;
    bit              failed = 1'b0;

    pow_difficulty_retarget dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Bit length of a 256-bit target
    function automatic int unsigned bit_length(logic [255:0] v);
        for (int i = 255; i >= 0; i--)
            if (v[i]) return i + 1;
        return 0;
    endfunction

    function automatic logic [31:0] pack_compact(logic [255:0] v);
        int unsigned nbytes;
        logic [31:0] mant;
        logic [255:0] sh;
        nbytes = (bit_length(v) + 7) / 8;
        if (nbytes <= 3) begin
            mant = v[31:0] << (8 * (3 - nbytes));
        end else begin
            sh = v >> (8 * (nbytes - 3));
            mant = sh[31:0];
        end
        mant &= 32'h00FF_FFFF;
        // mantissa must not look negative
        if (mant[23]) begin
            mant >>= 8;
            nbytes++;
        end
        return mant | (nbytes << 24);
    endfunction

    function automatic logic [31:0] next_target_bits(retarget_req_t r);
        logic [255:0] limit, tgt;
        longint span, lo, hi;
        int unsigned nbits, expo;
        bit halved;
        if (pass_through) return r.last_bits;
        nbits = (limit_bits > 256) ? 256 : limit_bits;
        limit = (nbits == 256) ? '1 : ((256'd1 << nbits) - 256'd1);
        if (span_target == 0) return pack_compact(limit);
        // clamp the measured span to T/4 .. 4T
        span = longint'({32'd0, r.last_time}) - longint'({32'd0, r.first_time});
        lo = span_target / 4;
        hi = longint'(span_target) * 4;
        if (span < lo) span = lo;
        if (span > hi) span = hi;
        // expand compact form, sign bit ignored
        expo = r.last_bits[31:24];
        if (expo <= 3)
            tgt = 256'(r.last_bits[22:0] >> (8 * (3 - expo)));
        else
            tgt = 256'(r.last_bits[22:0]) << (8 * (expo - 3));
        halved = bit_length(tgt) > HALVE_ABOVE;
        if (halved) tgt >>= 1;
        tgt = tgt * 256'(span);
        tgt = tgt / 256'(span_target);
        if (halved) tgt <<= 1;
        if (tgt > limit) tgt = limit;
        return pack_compact(tgt);
    endfunction

    // Input driver
    always @(posedge aclk) begin
        retarget_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_bits.push_back(next_target_bits('{s_last_bits, s_last_time,
                                                          s_first_time}));
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    s_valid      <= 1'b1;
                    s_last_bits  <= nxt.last_bits;
                    s_last_time  <= nxt.last_time;
                    s_first_time <= nxt.first_time;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and back-pressure
    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bits.size() == 0) begin
                    $error("next_bits: unexpected beat, actual %h", m_next_bits);
                    failed = 1'b1;
                end else begin
                    want = expected_bits.pop_front();
                    if (m_next_bits !== want) begin
                        $error("next_bits: expected %h, actual %h", want, m_next_bits);
                        failed = 1'b1;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_register(logic [1:0] idx, logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TIMESPAN:   span_target  = data[29:0];
            REG_LIMIT_BITS: limit_bits   = data[8:0];
            REG_NO_RETGT:   pass_through = data[0];
            default: ;
        endcase
    endtask

    // Wait for the pipeline to empty, then idle before the next phase
    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_bits.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic add_req(logic [31:0] lb, logic [31:0] lt, logic [31:0] ft);
        pending_reqs.push_back('{lb, lt, ft});
    endtask

    task automatic add_random_reqs(int unsigned count);
        logic [31:0] lb, ft;
        logic [63:0] delta;
        for (int i = 0; i < count; i++) begin
            lb = $urandom();
            case ($urandom_range(3))
                0:       lb[31:24] = 8'($urandom_range(0, 8'h22));
                1:       lb[31:24] = 8'($urandom_range(8'h1c, 8'h21));
                2:       lb[31:24] = 8'($urandom_range(0, 3));
                default: ;
            endcase
            ft = $urandom();
            case ($urandom_range(3))
                0:       delta = $urandom();
                1:       delta = 64'(span_target) * $urandom_range(0, 500) / 100;
                2:       delta = 64'(span_target / 4) + $urandom_range(0, 2) - 1;
                default: delta = 64'(span_target) * 4 + $urandom_range(0, 2) - 1;
            endcase
            add_req(lb, ft + delta[31:0], ft);
        end
    endtask

    initial begin
        logic [29:0] ts;
        logic [8:0]  lim;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed corners at reset settings
        add_req(32'h0000_0000, 32'd1000, 32'd1000);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        add_req(32'h1d00_ffff, 32'd302400, 32'd0);
        add_req(32'h1d00_ffff, 32'd0, 32'hFFFF_FFFF);
        add_req(32'h0312_3456, 32'd75600, 32'd0);
        add_req(32'h0100_3456, 32'd5000000, 32'd0);
        add_req(32'h0200_8000, 32'd1209600, 32'd0);
        add_req(32'h0492_3456, 32'd900000, 32'd10);
        add_req(32'h1e7f_ffff, 32'd1209601, 32'd0);
        add_req(32'h20ff_ffff, 32'd600000, 32'd1);
        add_req(32'h217f_ffff, 32'd302400, 32'd0);
        add_req(32'hff7f_ffff, 32'd400000, 32'd0);
        add_req(32'h0000_0001, 32'd0, 32'd0);
        drain();
        write_register(REG_NO_RETGT, 32'd1);
        add_req(32'h0480_0001, 32'd5, 32'd3);
        add_req(32'hFFFF_FFFF, 32'd0, 32'd7);
        drain();

        // Random phases: three back-pressure profiles, three settings each
        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin send_idle_pct = 10; recv_stall_pct = 80; end
                1: begin send_idle_pct = 80; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            case (ph)
                0: begin ts = 30'd302400;     lim = 9'd236; end
                1: begin ts = 30'd1;          lim = 9'd256; end
                2: begin ts = 30'h3FFF_FFFF;  lim = 9'd511; end
                3: begin ts = 30'd0;          lim = 9'd200; end
                4: begin ts = 30'($urandom()); lim = 9'd0;   end
                5: begin ts = 30'($urandom_range(1, 5000)); lim = 9'd1; end
                6: begin ts = 30'($urandom()); lim = 9'($urandom()); end
                7: begin ts = 30'd2016;       lim = 9'd255; end
                default: begin ts = 30'($urandom_range(1, 1 << 20)); lim = 9'd257; end
            endcase
            write_register(REG_TIMESPAN, {2'($urandom()), ts});
            write_register(REG_LIMIT_BITS, {23'($urandom()), lim});
            write_register(REG_NO_RETGT, {31'($urandom()), ph == 7});
            add_random_reqs(125);
            drain();
        end

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
